// File: rtl/core/slpg_pkg.sv
// ----------------------------------------------------------------------------
// slpg_pkg
// Shared types, colour codes and arithmetic helpers for the status LED
// pattern generator.
// ----------------------------------------------------------------------------
package slpg_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_DECIDE,
    S_DIV,
    S_SCALE,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    COL_WHITE = 3'd0,
    COL_BLUE  = 3'd1,
    COL_GREEN = 3'd2,
    COL_AMBER = 3'd3,
    COL_RED   = 3'd4,
    COL_OFF   = 3'd5
  } colour_t;

  // per channel palette entry: 0, 100 or 255
  typedef enum logic [1:0] {
    LV_ZERO,
    LV_FULL,
    LV_MID
  } chan_sel_t;

  typedef struct packed {
    chan_sel_t r;
    chan_sel_t g;
    chan_sel_t b;
  } pix_sel_t;

  localparam logic [2:0] REG_BRIGHTNESS_CAP = 3'd0;
  localparam logic [2:0] REG_SHORT_HOLD_MS  = 3'd1;
  localparam logic [2:0] REG_RESET_HOLD_MS  = 3'd2;
  localparam logic [2:0] REG_FLASH_LEN      = 3'd3;
  localparam logic [2:0] REG_BREATHE_LEN    = 3'd4;

  localparam logic [7:0]  RST_BRIGHTNESS_CAP = 8'd48;
  localparam logic [15:0] RST_SHORT_HOLD_MS  = 16'd1000;
  localparam logic [15:0] RST_RESET_HOLD_MS  = 16'd10000;
  localparam logic [7:0]  RST_FLASH_LEN      = 8'd33;
  localparam logic [9:0]  RST_BREATHE_LEN    = 10'd83;

  localparam logic [15:0] SOLID_LEFT_MS  = 16'd2000;
  localparam logic [7:0]  LEVEL_MAX      = 8'd255;
  localparam logic [7:0]  LEVEL_STEADY   = 8'd90;
  localparam logic [7:0]  LEVEL_MID      = 8'd100;
  localparam logic [7:0]  BREATHE_FLOOR  = 8'd30;
  localparam logic [7:0]  BREATHE_SPAN   = 8'd225;
  localparam logic [2:0]  STROBE_MOD     = 3'd6;
  localparam logic [2:0]  STROBE_ON      = 3'd3;
  localparam logic [3:0]  REFRESH_MOD    = 4'd10;
  localparam logic [8:0]  THIRD_MUL      = 9'd171;
  localparam int          THIRD_SHIFT    = 9;

  localparam int DIV_BITS = 18;
  localparam int DEN_BITS = 9;

  typedef struct packed {
    logic       done;
    logic [9:0] rem_p;
    logic [2:0] rem6;
    logic [3:0] rem10;
  } mod_rsp_t;

  typedef struct packed {
    logic                start;
    logic [DIV_BITS-1:0] num;
    logic [DEN_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_BITS-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic       start;
    colour_t    colour;
    logic [7:0] level;
  } scl_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } scl_rsp_t;

  // exact x / 255 for any product of two bytes
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    begin
      t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
      return t[15:8];
    end
  endfunction

  function automatic pix_sel_t palette_sel(input colour_t c);
    pix_sel_t p;
    begin
      case (c)
        COL_WHITE: p = '{LV_FULL, LV_FULL, LV_FULL};
        COL_BLUE:  p = '{LV_ZERO, LV_ZERO, LV_FULL};
        COL_GREEN: p = '{LV_ZERO, LV_FULL, LV_ZERO};
        COL_AMBER: p = '{LV_FULL, LV_MID, LV_ZERO};
        COL_RED:   p = '{LV_FULL, LV_ZERO, LV_ZERO};
        default:   p = '{LV_ZERO, LV_ZERO, LV_ZERO};
      endcase
      return p;
    end
  endfunction

endpackage

// File: rtl/core/slpg_mod_unit.sv
// ----------------------------------------------------------------------------
// slpg_mod_unit
// Bit-serial residues of the tick count modulo the breathe period, 6 and 10,
// one tick bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module slpg_mod_unit #(
  parameter int TICK_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [TICK_BITS-1:0]  tick,
  input  logic [9:0]            period,
  output slpg_pkg::mod_rsp_t    rsp
);
  import slpg_pkg::*;

  localparam int CW = $clog2(TICK_BITS + 1);

  logic [TICK_BITS-1:0] shreg;
  logic [CW-1:0]        cnt;
  logic                 busy;
  logic                 done;
  logic [9:0]           rem_p;
  logic [2:0]           rem6;
  logic [3:0]           rem10;
  logic                 b;
  logic [10:0]          tp;
  logic [3:0]           t6;
  logic [4:0]           t10;
  logic [9:0]           rem_p_next;
  logic [2:0]           rem6_next;
  logic [3:0]           rem10_next;

  always_comb begin
    b   = shreg[TICK_BITS-1];
    tp  = {rem_p, b};
    t6  = {rem6, b};
    t10 = {rem10, b};
    rem_p_next = (tp >= {1'b0, period}) ? 10'(tp - {1'b0, period}) : tp[9:0];
    rem6_next  = (t6 >= {1'b0, STROBE_MOD}) ? 3'(t6 - {1'b0, STROBE_MOD}) : t6[2:0];
    rem10_next = (t10 >= {1'b0, REFRESH_MOD}) ? 4'(t10 - {1'b0, REFRESH_MOD}) : t10[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(TICK_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= tick;
      rem_p <= '0;
      rem6  <= '0;
      rem10 <= '0;
    end else if (busy) begin
      shreg <= {shreg[TICK_BITS-2:0], 1'b0};
      rem_p <= rem_p_next;
      rem6  <= rem6_next;
      rem10 <= rem10_next;
    end
  end

  assign rsp.done  = done;
  assign rsp.rem_p = rem_p;
  assign rsp.rem6  = rem6;
  assign rsp.rem10 = rem10;

endmodule

// File: rtl/core/slpg_div_unit.sv
// ----------------------------------------------------------------------------
// slpg_div_unit
// Restoring bit-serial divider for the breathe level, one quotient bit per
// cycle.
// ----------------------------------------------------------------------------
module slpg_div_unit (
  input  logic               clk,
  input  logic               rst,
  input  slpg_pkg::div_req_t req,
  output slpg_pkg::div_rsp_t rsp
);
  import slpg_pkg::*;

  localparam int CW = $clog2(DIV_BITS + 1);

  logic [DIV_BITS-1:0] quo;
  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] den;
  logic [CW-1:0]       cnt;
  logic                busy;
  logic                done;
  logic [DEN_BITS:0]   t;
  logic                qbit;
  logic [DEN_BITS-1:0] rem_next;

  always_comb begin
    t    = {rem, quo[DIV_BITS-1]};
    qbit = (t >= {1'b0, den});
    rem_next = qbit ? DEN_BITS'(t - {1'b0, den}) : t[DEN_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.num;
      den <= req.den;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DIV_BITS-2:0], qbit};
      rem <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

// File: rtl/core/slpg_scaler.sv
// ----------------------------------------------------------------------------
// slpg_scaler
// Scales the palette colour by the animation level and then by the
// brightness cap, each step truncating by 255.
// ----------------------------------------------------------------------------
module slpg_scaler (
  input  logic               clk,
  input  logic               rst,
  input  slpg_pkg::scl_req_t req,
  input  logic [7:0]         cap,
  output slpg_pkg::scl_rsp_t rsp
);
  import slpg_pkg::*;

  logic [3:0]  vld;
  colour_t     col;
  logic [7:0]  lvl;
  logic [15:0] p100;
  logic [7:0]  s100;
  logic [15:0] pa;
  logic [15:0] pb;
  logic [7:0]  qa;
  logic [7:0]  qb;
  pix_sel_t    sel;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  function automatic logic [7:0] pick(input chan_sel_t s, input logic [7:0] full,
                                      input logic [7:0] mid);
    logic [7:0] v;
    begin
      case (s)
        LV_FULL: v = full;
        LV_MID:  v = mid;
        default: v = 8'd0;
      endcase
      return v;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], req.start};
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      col  <= req.colour;
      lvl  <= req.level;
      p100 <= 16'(req.level) * 16'(LEVEL_MID);
    end
    if (vld[0]) begin
      s100 <= div255(p100);
    end
    if (vld[1]) begin
      pa <= 16'(lvl) * 16'(cap);
      pb <= 16'(s100) * 16'(cap);
    end
    if (vld[2]) begin
      red   <= pick(sel.r, qa, qb);
      green <= pick(sel.g, qa, qb);
      blue  <= pick(sel.b, qa, qb);
    end
  end

  always_comb begin
    sel = palette_sel(col);
    qa  = div255(pa);
    qb  = div255(pb);
  end

  assign rsp.done  = vld[3];
  assign rsp.red   = red;
  assign rsp.green = green;
  assign rsp.blue  = blue;

endmodule

// File: rtl/core/status_led_pattern_generator.sv
// ----------------------------------------------------------------------------
// status_led_pattern_generator
// One animation tick in, one dimmed RGB pixel out, chosen by button hold,
// relay confirm flash, provisioning and connectivity state.
// ----------------------------------------------------------------------------
// One tick is handled at a time. The tick count is reduced modulo the
// breathe period, 6 and 10 one bit per cycle; when the pixel breathes, the
// breathe level comes from a serial divider; then the level and cap scaling
// runs through a registered pipeline. The result sits in an output register,
// so a new tick is taken while the previous pixel waits; the next pixel is
// held back until that one is taken. The user is to write configuration
// only while the block is idle; the block itself does not enforce this. One
// register is written per transaction; unknown indexes are ignored.
module status_led_pattern_generator #(
  parameter int TICK_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [15:0]          held_ms,
  input  logic                 relay_on,
  input  logic                 provisioned,
  input  logic                 ble_connected,
  input  logic                 link_up,
  input  logic                 cloud_ready,
  input  logic [1:0]           prov_state,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           red,
  output logic [7:0]           green,
  output logic [7:0]           blue
);
  import slpg_pkg::*;

  // configuration
  logic [7:0]  brightness_cap;
  logic [15:0] short_hold_ms;
  logic [15:0] reset_hold_ms;
  logic [7:0]  confirm_len;
  logic [9:0]  breathe_len;

  // pattern state
  logic [TICK_BITS-1:0] tick_count;
  logic                 prev_relay;
  logic                 relay_seen;
  logic [7:0]           confirm_left;
  logic                 confirm_state;
  colour_t              base_colour;
  logic                 setup_mode;

  // captured tick
  logic [15:0] held_r;
  logic        relay_r;
  logic        prov_r;
  logic        ble_r;
  logic        link_r;
  logic        cloud_r;
  logic [1:0]  pstate_r;

  state_t   state;
  state_t   state_next;
  colour_t  col_r;
  mod_rsp_t mod_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;
  scl_req_t scl_req;
  scl_rsp_t scl_rsp;
  logic     in_acc;
  logic     mod_start;
  logic     out_load;

  // decision
  logic       prev_relay_next;
  logic       relay_seen_next;
  logic [7:0] confirm_left_next;
  logic       confirm_state_next;
  colour_t    base_colour_next;
  logic       setup_mode_next;
  colour_t    col_d;
  logic [7:0] lvl_d;
  logic       brth_d;
  logic       near_wipe;
  logic [7:0] third;
  logic [7:0] cl_dec;
  logic [8:0] half;
  logic [9:0] up;
  logic [7:0] brth_lvl;
  logic [7:0] blink_lvl;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness_cap <= RST_BRIGHTNESS_CAP;
      short_hold_ms  <= RST_SHORT_HOLD_MS;
      reset_hold_ms  <= RST_RESET_HOLD_MS;
      confirm_len    <= RST_FLASH_LEN;
      breathe_len    <= RST_BREATHE_LEN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BRIGHTNESS_CAP: brightness_cap <= cfg_data[7:0];
        REG_SHORT_HOLD_MS:  short_hold_ms  <= cfg_data;
        REG_RESET_HOLD_MS:  reset_hold_ms  <= cfg_data;
        REG_FLASH_LEN:      confirm_len    <= cfg_data[7:0];
        REG_BREATHE_LEN:    breathe_len    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  slpg_mod_unit #(
    .TICK_BITS (TICK_BITS)
  ) u_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (mod_start),
    .tick   (tick_count + 1'b1),
    .period (breathe_len),
    .rsp    (mod_rsp)
  );

  slpg_div_unit u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  slpg_scaler u_scl (
    .clk (clk),
    .rst (rst),
    .req (scl_req),
    .cap (brightness_cap),
    .rsp (scl_rsp)
  );

  // priority decision on the captured tick
  always_comb begin
    relay_seen_next    = relay_seen;
    prev_relay_next    = prev_relay;
    confirm_left_next  = confirm_left;
    confirm_state_next = confirm_state;
    base_colour_next   = base_colour;
    setup_mode_next    = setup_mode;
    col_d              = COL_OFF;
    lvl_d              = 8'd0;
    brth_d             = 1'b0;

    if (!relay_seen) begin
      relay_seen_next = 1'b1;
      prev_relay_next = relay_r;
    end else if (relay_r != prev_relay) begin
      confirm_left_next  = confirm_len;
      confirm_state_next = relay_r;
      prev_relay_next    = relay_r;
    end

    near_wipe = (held_r >= reset_hold_ms) || ((reset_hold_ms - held_r) <= SOLID_LEFT_MS);
    third     = 8'((17'(confirm_len) * 17'(THIRD_MUL)) >> THIRD_SHIFT);
    cl_dec    = confirm_left_next - 1'b1;
    blink_lvl = tick_count[3] ? 8'd0 : LEVEL_MAX;

    if (held_r >= short_hold_ms) begin
      col_d = COL_RED;
      lvl_d = (near_wipe || (mod_rsp.rem6 < STROBE_ON)) ? LEVEL_MAX : 8'd0;
    end else if (held_r != 16'd0) begin
      col_d             = COL_OFF;
      lvl_d             = 8'd0;
      confirm_left_next = 8'd0;
    end else if (confirm_left_next != 8'd0) begin
      confirm_left_next = cl_dec;
      lvl_d             = LEVEL_MAX;
      if ({1'b0, cl_dec} > {third, 1'b0}) begin
        col_d = COL_WHITE;
      end else if (cl_dec > third) begin
        col_d = confirm_state_next ? COL_GREEN : COL_RED;
      end else begin
        col_d = COL_WHITE;
      end
    end else begin
      if (mod_rsp.rem10 == 4'd0) begin
        setup_mode_next = !prov_r;
        if (!prov_r) begin
          base_colour_next = COL_WHITE;
        end else if (ble_r) begin
          base_colour_next = COL_BLUE;
        end else if (link_r && cloud_r) begin
          base_colour_next = COL_GREEN;
        end else begin
          base_colour_next = COL_AMBER;
        end
      end
      if (setup_mode_next) begin
        if (pstate_r == 2'd1) begin
          col_d = COL_GREEN;
          lvl_d = blink_lvl;
        end else if (pstate_r[1]) begin
          col_d = COL_RED;
          lvl_d = blink_lvl;
        end else begin
          col_d  = COL_WHITE;
          brth_d = 1'b1;
        end
      end else if (relay_r) begin
        col_d  = base_colour_next;
        brth_d = 1'b1;
      end else begin
        col_d = base_colour_next;
        lvl_d = LEVEL_STEADY;
      end
    end
  end

  // breathe triangle
  always_comb begin
    half = breathe_len[9:1];
    up   = (mod_rsp.rem_p < {1'b0, half}) ? mod_rsp.rem_p : breathe_len - mod_rsp.rem_p;
    brth_lvl = (div_rsp.quo >= DIV_BITS'(LEVEL_MAX - BREATHE_FLOOR + 8'd1)) ? LEVEL_MAX
             : 8'(div_rsp.quo[7:0] + BREATHE_FLOOR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    mod_start      = 1'b0;
    out_load       = 1'b0;
    div_req.start  = 1'b0;
    div_req.num    = DIV_BITS'(up) * DIV_BITS'(BREATHE_SPAN);
    div_req.den    = half;
    scl_req.start  = 1'b0;
    scl_req.colour = col_d;
    scl_req.level  = lvl_d;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mod_start  = 1'b1;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_rsp.done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (brth_d && (half != 9'd0)) begin
          div_req.start = 1'b1;
          state_next    = S_DIV;
        end else begin
          scl_req.start = 1'b1;
          scl_req.level = brth_d ? LEVEL_MAX : lvl_d;
          state_next    = S_SCALE;
        end
      end
      S_DIV: begin
        scl_req.colour = col_r;
        scl_req.level  = brth_lvl;
        if (div_rsp.done) begin
          scl_req.start = 1'b1;
          state_next    = S_SCALE;
        end
      end
      S_SCALE: begin
        if (scl_rsp.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      prev_relay    <= 1'b0;
      relay_seen    <= 1'b0;
      confirm_left  <= '0;
      confirm_state <= 1'b0;
      base_colour   <= COL_WHITE;
      setup_mode    <= 1'b1;
    end else begin
      if (in_acc) begin
        tick_count <= tick_count + 1'b1;
      end
      if (state == S_DECIDE) begin
        prev_relay    <= prev_relay_next;
        relay_seen    <= relay_seen_next;
        confirm_left  <= confirm_left_next;
        confirm_state <= confirm_state_next;
        base_colour   <= base_colour_next;
        setup_mode    <= setup_mode_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      held_r   <= held_ms;
      relay_r  <= relay_on;
      prov_r   <= provisioned;
      ble_r    <= ble_connected;
      link_r   <= link_up;
      cloud_r  <= cloud_ready;
      pstate_r <= prov_state;
    end
    if (state == S_DECIDE) begin
      col_r <= col_d;
    end
    if (out_load) begin
      red   <= scl_rsp.red;
      green <= scl_rsp.green;
      blue  <= scl_rsp.blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/core/slpg_checker.sv
// ----------------------------------------------------------------------------
// slpg_checker
// Port-level checks for the status LED pattern generator, bound to the top.
// ----------------------------------------------------------------------------
module slpg_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue
);

  // stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // stalled pixel unchanged
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable({red, green, blue}))
    else $error("pixel changed while stalled");

  // one tick in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  // no result right after a tick is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // clean state out of reset
  a_reset_idle: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> in_ready && !out_valid)
    else $error("not idle after reset");

endmodule

bind status_led_pattern_generator slpg_checker u_slpg_checker (.*);

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the status LED pattern generator. Ticks with held
// button time, relay edges, provisioning and link flags are driven over the
// valid/ready input channel under several register settings and idle
// patterns; a scoreboard class predicts every RGB pixel and compares it with
// the block's output in order.
// ----------------------------------------------------------------------------
module tb;
  import slpg_pkg::*;

  localparam logic [1:0] PROV_WAIT       = 2'd0;
  localparam logic [1:0] PROV_JOINING    = 2'd1;
  localparam logic [1:0] PROV_NET_FAIL   = 2'd2;
  localparam logic [1:0] PROV_FAULT      = 2'd3;
  localparam int         REG_COUNT       = 5;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  class pixel_scoreboard;
    logic [7:0]  cap;
    logic [15:0] short_hold;
    logic [15:0] wipe_hold;
    logic [7:0]  flash_len;
    logic [9:0]  breathe_period;
    logic [31:0] tick;
    logic        prior_relay;
    logic        relay_known;
    logic [7:0]  flash_left;
    logic        flash_relay;
    colour_t     rest_colour;
    logic        in_setup;
    pixel_t      expected_q[$];
    int          errors, checked, writes;
    int          n_hold, n_dark, n_flash, n_setup, n_linked;

    function new();
      cap            = RST_BRIGHTNESS_CAP;
      short_hold     = RST_SHORT_HOLD_MS;
      wipe_hold      = RST_RESET_HOLD_MS;
      flash_len      = RST_FLASH_LEN;
      breathe_period = RST_BREATHE_LEN;
      tick           = '0;
      prior_relay    = 1'b0;
      relay_known    = 1'b0;
      flash_left     = '0;
      flash_relay    = 1'b0;
      rest_colour    = COL_WHITE;
      in_setup       = 1'b1;
      errors   = 0;
      checked  = 0;
      writes   = 0;
      n_hold   = 0;
      n_dark   = 0;
      n_flash  = 0;
      n_setup  = 0;
      n_linked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      writes++;
      case (idx)
        REG_BRIGHTNESS_CAP: cap = data[7:0];
        REG_SHORT_HOLD_MS:  short_hold = data;
        REG_RESET_HOLD_MS:  wipe_hold = data;
        REG_FLASH_LEN:      flash_len = data[7:0];
        REG_BREATHE_LEN:    breathe_period = data[9:0];
        default: ;
      endcase
    endfunction

    function int unsigned base_level(colour_t c, int ch);
      case (c)
        COL_WHITE: return 255;
        COL_BLUE:  return (ch == 2) ? 255 : 0;
        COL_GREEN: return (ch == 1) ? 255 : 0;
        COL_AMBER: return (ch == 0) ? 255 : (ch == 1) ? 100 : 0;
        COL_RED:   return (ch == 0) ? 255 : 0;
        default:   return 0;
      endcase
    endfunction

    function pixel_t shade(colour_t c, int unsigned level);
      pixel_t      px;
      int unsigned v[3];
      for (int ch = 0; ch < 3; ch++) begin
        v[ch] = base_level(c, ch) * level / 255;
        v[ch] = v[ch] * cap / 255;
      end
      px.r = 8'(v[0]);
      px.g = 8'(v[1]);
      px.b = 8'(v[2]);
      return px;
    endfunction

    function int unsigned breathe_level();
      int unsigned half, x, up, lv;
      half = breathe_period / 2;
      if (half == 0) return 255;
      x  = tick % breathe_period;
      up = (x < half) ? x : breathe_period - x;
      lv = 30 + up * 225 / half;
      return (lv > 255) ? 255 : lv;
    endfunction

    function void note_tick(logic [15:0] held, logic relay, logic prov, logic ble,
                            logic link, logic cloud, logic [1:0] pstate);
      pixel_t      px;
      int unsigned left, third, blink;
      colour_t     c;
      tick = tick + 1;
      // first tick only latches the relay
      if (!relay_known) begin
        relay_known = 1'b1;
        prior_relay = relay;
      end else if (relay != prior_relay) begin
        flash_left  = flash_len;
        flash_relay = relay;
        prior_relay = relay;
      end
      if (held >= short_hold) begin
        n_hold++;
        left = (held < wipe_hold) ? wipe_hold - held : 0;
        if (left <= 2000) px = shade(COL_RED, 255);
        else px = shade(COL_RED, (tick % 6 < 3) ? 255 : 0);
      end else if (held > 0) begin
        n_dark++;
        px = shade(COL_OFF, 0);
        flash_left = '0;
      end else if (flash_left > 0) begin
        n_flash++;
        third = flash_len / 3;
        flash_left = flash_left - 8'd1;
        if (flash_left > 2 * third) c = COL_WHITE;
        else if (flash_left > third) c = flash_relay ? COL_GREEN : COL_RED;
        else c = COL_WHITE;
        px = shade(c, 255);
      end else begin
        // resting colour only refreshes every tenth tick
        if (tick % 10 == 0) begin
          in_setup = !prov;
          if (!prov) rest_colour = COL_WHITE;
          else if (ble) rest_colour = COL_BLUE;
          else if (link && cloud) rest_colour = COL_GREEN;
          else rest_colour = COL_AMBER;
        end
        if (in_setup) begin
          n_setup++;
          blink = (tick % 16 < 8) ? 255 : 0;
          if (pstate == PROV_JOINING) px = shade(COL_GREEN, blink);
          else if (pstate >= PROV_NET_FAIL) px = shade(COL_RED, blink);
          else px = shade(COL_WHITE, breathe_level());
        end else begin
          n_linked++;
          px = shade(rest_colour, relay ? breathe_level() : 90);
        end
      end
      expected_q.push_back(px);
    endfunction

    function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pixel_t want;
      if (expected_q.size() == 0) begin
        $error("pixel with nothing expected: red %0d green %0d blue %0d", r, g, b);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (r !== want.r) begin
        $error("red: expected %0d, got %0d", want.r, r);
        errors++;
      end
      if (g !== want.g) begin
        $error("green: expected %0d, got %0d", want.g, g);
        errors++;
      end
      if (b !== want.b) begin
        $error("blue: expected %0d, got %0d", want.b, b);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] held_ms = '0;
  logic        relay_on = 1'b0;
  logic        provisioned = 1'b0;
  logic        ble_connected = 1'b0;
  logic        link_up = 1'b0;
  logic        cloud_ready = 1'b0;
  logic [1:0]  prov_state = PROV_WAIT;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  red, green, blue;

  pixel_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // slowly changing link environment for the random ticks
  logic       env_relay, env_prov, env_ble, env_link, env_cloud;
  logic [1:0] env_pstate;
  int         run_left = 0;
  logic       in_hold = 1'b0;

  status_led_pattern_generator uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .held_ms      (held_ms),
    .relay_on     (relay_on),
    .provisioned  (provisioned),
    .ble_connected(ble_connected),
    .link_up      (link_up),
    .cloud_ready  (cloud_ready),
    .prov_state   (prov_state),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .red          (red),
    .green        (green),
    .blue         (blue)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_pixel(red, green, blue);
  end

  initial begin
    #10000000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic wait_drain();
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic send_tick(logic [15:0] held, logic relay, logic prov, logic ble,
                           logic link, logic cloud, logic [1:0] pstate);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    held_ms       = held;
    relay_on      = relay;
    provisioned   = prov;
    ble_connected = ble;
    link_up       = link;
    cloud_ready   = cloud;
    prov_state    = pstate;
    in_valid      = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_tick(held, relay, prov, ble, link, cloud, pstate);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // unused upper data bits carry noise to check the register slicing
  task automatic set_regs(logic [7:0] cap, logic [15:0] short_hold, logic [15:0] wipe_hold,
                          logic [7:0] flash_len, logic [9:0] period);
    in_valid = 1'b0;
    wait_drain();
    cfg_write(REG_BRIGHTNESS_CAP, (16'($urandom) & 16'hFF00) | 16'(cap));
    cfg_write(REG_SHORT_HOLD_MS, short_hold);
    cfg_write(REG_RESET_HOLD_MS, wipe_hold);
    cfg_write(REG_FLASH_LEN, (16'($urandom) & 16'hFF00) | 16'(flash_len));
    cfg_write(REG_BREATHE_LEN, (16'($urandom) & 16'hFC00) | 16'(period));
    cfg_write(3'($urandom_range(REG_COUNT, 7)), 16'($urandom));
    cfg_valid = 1'b0;
  endtask

  function automatic logic [15:0] near(int unsigned centre);
    int v;
    v = int'(centre) + $urandom_range(0, 2) - 1;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  function automatic logic [15:0] pick_held();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 20) return (sb.short_hold > 1) ? 16'($urandom_range(1, sb.short_hold - 1)) : 16'd1;
    if (k < 40) return 16'($urandom);
    if (k < 55) return near(sb.short_hold);
    if (k < 70) return (sb.wipe_hold >= 2000) ? near(sb.wipe_hold - 2000) : 16'($urandom);
    if (k < 85) return near(sb.wipe_hold);
    if (k < 93) return 16'hFFFF;
    return 16'd1;
  endfunction

  task automatic run_ticks(int n, int idle_pct, int stall_pct);
    logic [15:0] held;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 79) == 0) begin
        in_valid = 1'b0;
        wait_drain();
      end
      if ($urandom_range(0, 29) == 0) begin
        env_prov   = ($urandom_range(0, 3) != 0);
        env_ble    = 1'($urandom);
        env_link   = 1'($urandom);
        env_cloud  = 1'($urandom);
        env_pstate = 2'($urandom);
      end
      if ($urandom_range(0, 14) == 0) env_relay = ~env_relay;
      // quiet stretches long enough for flashes, short bursts of button holds
      if (run_left == 0) begin
        in_hold  = ($urandom_range(0, 4) == 0);
        run_left = in_hold ? $urandom_range(1, 6) : $urandom_range(4, 40);
      end
      run_left--;
      held = in_hold ? pick_held() : 16'd0;
      if ($urandom_range(0, 19) == 0)
        send_tick(16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                  1'($urandom), 1'($urandom), 2'($urandom));
      else
        send_tick(held, env_relay, env_prov, env_ble, env_link, env_cloud, env_pstate);
    end
  endtask

  initial begin
    sb = new();
    env_relay  = 1'b0;
    env_prov   = 1'b1;
    env_ble    = 1'b0;
    env_link   = 1'b1;
    env_cloud  = 1'b1;
    env_pstate = PROV_WAIT;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed ticks at reset settings
    send_tick(16'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PROV_WAIT);
    send_tick(16'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PROV_JOINING);
    send_tick(16'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PROV_NET_FAIL);
    send_tick(16'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PROV_FAULT);
    send_tick(16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PROV_WAIT);
    send_tick(16'd8000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PROV_WAIT);
    send_tick(16'd7999, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PROV_WAIT);
    send_tick(16'd1000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PROV_WAIT);
    send_tick(16'd999, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PROV_WAIT);
    send_tick(16'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PROV_WAIT);
    repeat (4) send_tick(16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PROV_WAIT);
    send_tick(16'd500, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PROV_WAIT);
    send_tick(16'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PROV_WAIT);
    send_tick(16'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PROV_WAIT);
    send_tick(16'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PROV_WAIT);
    repeat (7) send_tick(16'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, PROV_WAIT);

    set_regs(8'd255, 16'd1000, 16'd10000, 8'd33, 10'd83);
    run_ticks(120, 0, 0);
    set_regs(8'd0, 16'hFFFF, 16'hFFFF, 8'd255, 10'd1023);
    run_ticks(100, 74, 0);
    set_regs(8'd255, 16'd0, 16'd0, 8'd3, 10'd0);
    run_ticks(50, 0, 74);
    set_regs(8'd128, 16'd200, 16'd2500, 8'd0, 10'd1);
    run_ticks(100, 17, 17);
    set_regs(8'd200, 16'd5000, 16'd3000, 8'd1, 10'd2);
    run_ticks(80, 0, 0);
    set_regs(8'($urandom), 16'($urandom_range(1, 4000)), 16'($urandom), 8'd2, 10'd5);
    run_ticks(100, 74, 0);
    set_regs(8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
             10'($urandom_range(0, 511) * 2 + 1));
    run_ticks(100, 0, 74);
    set_regs(8'd255, 16'd1000, 16'd10000, 8'd255, 10'd1023);
    run_ticks(100, 17, 17);

    in_valid = 1'b0;
    wait_drain();
    repeat (80) @(posedge clk);
    $display("checked %0d pixels after %0d register writes", sb.checked, sb.writes);
    $display("ticks by branch: hold %0d, dark %0d, flash %0d, setup %0d, linked %0d",
             sb.n_hold, sb.n_dark, sb.n_flash, sb.n_setup, sb.n_linked);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// File: status_led_pattern_generator.f
rtl/core/slpg_pkg.sv
rtl/core/slpg_mod_unit.sv
rtl/core/slpg_div_unit.sv
rtl/core/slpg_scaler.sv
rtl/core/status_led_pattern_generator.sv
rtl/core/slpg_checker.sv
test/tb.sv
